FILE: design/act_pkg.sv
package act_pkg;

   // Table geometry.
   localparam int ENTRIES = 64;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Field widths.
   localparam int IP_W       = 32;
   localparam int MAC_W      = 48;
   localparam int TIME_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30000;
   localparam logic [TIME_W-1:0] GAP_RESET     = 32'd200;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUEST_GAP   = 2'd1;

   // Command codes.
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             hit;
      logic [MAC_W-1:0] mac;
      idx_type          target;
   } scan_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_WRITE
   } state_type;

endpackage

FILE: design/act_ram.sv
module act_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/act_scan_unit.sv
module act_scan_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              step_en,
   input  act_pkg::idx_type                  step_idx,
   input  logic                              slot_valid,
   input  act_pkg::entry_type                slot,
   input  logic                              cmd,
   input  logic [act_pkg::IP_W-1:0]          ip_addr,
   input  logic [act_pkg::TIME_W-1:0]        now_ms,
   input  logic [act_pkg::TIME_W-1:0]        timeout_ms,
   output logic                              expire,
   output act_pkg::scan_res_type             result
);

   logic                         match_found_ff, match_found_in;
   act_pkg::idx_type             match_idx_ff, match_idx_in;
   logic                         free_found_ff, free_found_in;
   act_pkg::idx_type             free_idx_ff, free_idx_in;
   logic                         min_seen_ff, min_seen_in;
   logic [act_pkg::TIME_W-1:0]   min_stamp_ff, min_stamp_in;
   act_pkg::idx_type             min_idx_ff, min_idx_in;
   logic                         hit_ff, hit_in;
   logic [act_pkg::MAC_W-1:0]    mac_ff, mac_in;

   logic                         same_ip;
   logic [act_pkg::TIME_W-1:0]   age;
   logic                         too_old;
   logic                         is_lookup;

   // One slot is judged per cycle by this compare unit.
   assign same_ip   = slot_valid && (slot.ip == ip_addr);
   assign age       = now_ms - slot.stamp;
   assign too_old   = age > timeout_ms;
   assign is_lookup = (cmd == act_pkg::CMD_LOOKUP);
   assign expire    = step_en && is_lookup && same_ip && !hit_ff && too_old;

   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      min_seen_in    = min_seen_ff;
      min_stamp_in   = min_stamp_ff;
      min_idx_in     = min_idx_ff;
      hit_in         = hit_ff;
      mac_in         = mac_ff;
      if (start) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         min_seen_in    = 1'b0;
         hit_in         = 1'b0;
      end else if (step_en) begin
         if (same_ip && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = step_idx;
         end
         if (!slot_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = step_idx;
         end
         if (!min_seen_ff || (slot.stamp < min_stamp_ff)) begin
            min_seen_in  = 1'b1;
            min_stamp_in = slot.stamp;
            min_idx_in   = step_idx;
         end
         if (is_lookup && same_ip && !hit_ff && !too_old) begin
            hit_in = 1'b1;
            mac_in = slot.mac;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         min_seen_ff    <= 1'b0;
         hit_ff         <= 1'b0;
      end else begin
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         min_seen_ff    <= min_seen_in;
         hit_ff         <= hit_in;
      end
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      min_stamp_ff <= min_stamp_in;
      min_idx_ff   <= min_idx_in;
      mac_ff       <= mac_in;
   end

   always_comb begin
      result.hit = hit_ff;
      result.mac = mac_ff;
      priority if (match_found_ff) begin
         result.target = match_idx_ff;
      end else if (free_found_ff) begin
         result.target = free_idx_ff;
      end else begin
         result.target = min_idx_ff;
      end
   end

endmodule

FILE: design/arp_cache_table_top.sv
// Flow: an accepted transaction reads every slot in ST_SCAN, finishes the last compare in ST_LAST
// and in ST_WRITE loads the output register once it is free (an update also writes its slot).
// The block takes no new transaction until it has finished the last one; the single read port
// of the slot table, read once per slot by the shared compare unit, paces each transaction.
// Reset (synchronous, active high) clears all valid bits, the last request time and the
// handshake state, and loads the registers with their defaults; no clearing pass is needed.
module arp_cache_table_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [act_pkg::IP_W-1:0]            req_ip_addr,
   input  logic [act_pkg::MAC_W-1:0]           req_mac_in,
   input  logic [act_pkg::TIME_W-1:0]          req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [act_pkg::MAC_W-1:0]           rsp_mac_out,
   output logic                                rsp_send_request,
   input  logic                                csr_wr_en,
   input  logic [act_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [act_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Sequencer state and scan counter.
   act_pkg::state_type            state_ff, state_in;
   act_pkg::idx_type              cnt_ff, cnt_in;
   logic                          pipe_vld_ff, pipe_vld_in;
   act_pkg::idx_type              pipe_idx_ff, pipe_idx_in;

   // The transaction being worked on.
   logic                          cmd_ff, cmd_in;
   logic [act_pkg::IP_W-1:0]      ip_ff, ip_in;
   logic [act_pkg::MAC_W-1:0]     mac_ff, mac_in;
   logic [act_pkg::TIME_W-1:0]    now_ff, now_in;

   // Configuration and persistent state.
   logic [act_pkg::TIME_W-1:0]    timeout_ff, timeout_in;
   logic [act_pkg::TIME_W-1:0]    gap_ff, gap_in;
   logic [act_pkg::TIME_W-1:0]    last_req_ff, last_req_in;
   logic [act_pkg::ENTRIES-1:0]   valid_ff, valid_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [act_pkg::MAC_W-1:0]     rsp_mac_ff, rsp_mac_in;
   logic                          rsp_req_ff, rsp_req_in;

   // Sequencer outputs.
   logic                          accept;
   logic                          rd_en;
   logic                          scan_start;
   logic                          load_rsp;
   logic                          wr_en;
   logic                          out_free;

   act_pkg::entry_type            rd_entry;
   act_pkg::entry_type            wr_entry;
   logic                          expire;
   act_pkg::scan_res_type         scan_res;
   logic [act_pkg::TIME_W-1:0]    since;
   logic                          raise_req;

   // The output register frees up in the same cycle its result is taken.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   // Slot table: one write port and one registered read port.
   assign wr_entry.ip    = ip_ff;
   assign wr_entry.mac   = mac_ff;
   assign wr_entry.stamp = now_ff;

   act_ram #(
      .WIDTH (act_pkg::ENTRY_W),
      .DEPTH (act_pkg::ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (scan_res.target),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_entry)
   );

   // Shared compare unit: it sees each slot the cycle after its read was issued.
   act_scan_unit u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .step_en    (pipe_vld_ff),
      .step_idx   (pipe_idx_ff),
      .slot_valid (valid_ff[pipe_idx_ff]),
      .slot       (rd_entry),
      .cmd        (cmd_ff),
      .ip_addr    (ip_ff),
      .now_ms     (now_ff),
      .timeout_ms (timeout_ff),
      .expire     (expire),
      .result     (scan_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         act_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = act_pkg::ST_SCAN;
            end
         end
         act_pkg::ST_SCAN: begin
            if (cnt_ff == act_pkg::idx_type'(act_pkg::ENTRIES - 1)) begin
               state_in = act_pkg::ST_LAST;
            end
         end
         act_pkg::ST_LAST: begin
            state_in = act_pkg::ST_WRITE;
         end
         act_pkg::ST_WRITE: begin
            if (out_free) begin
               state_in = act_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = act_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall  = 1'b1;
      rd_en      = 1'b0;
      scan_start = 1'b0;
      load_rsp   = 1'b0;
      wr_en      = 1'b0;
      unique case (state_ff)
         act_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            scan_start = req_valid;
         end
         act_pkg::ST_SCAN: begin
            rd_en = 1'b1;
         end
         act_pkg::ST_LAST: begin
         end
         act_pkg::ST_WRITE: begin
            load_rsp = out_free;
            wr_en    = out_free && (cmd_ff == act_pkg::CMD_UPDATE);
         end
         default: begin
         end
      endcase
   end

   // A lookup miss raises a request only when the gap since the last one has run out.
   assign since     = now_ff - last_req_ff;
   assign raise_req = (cmd_ff == act_pkg::CMD_LOOKUP) && !scan_res.hit && (since > gap_ff);

   always_comb begin
      cnt_in      = (state_ff == act_pkg::ST_SCAN) ? cnt_ff + 1'b1 : '0;
      pipe_vld_in = rd_en;
      pipe_idx_in = cnt_ff;

      cmd_in = cmd_ff;
      ip_in  = ip_ff;
      mac_in = mac_ff;
      now_in = now_ff;
      if (accept) begin
         cmd_in = req_cmd;
         ip_in  = req_ip_addr;
         mac_in = req_mac_in;
         now_in = req_now_ms;
      end

      // The user makes configuration writes only while idle; the block does not enforce it.
      timeout_in = timeout_ff;
      gap_in     = gap_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            act_pkg::CSR_ENTRY_TIMEOUT: timeout_in = csr_wdata;
            act_pkg::CSR_REQUEST_GAP:   gap_in     = csr_wdata;
            default: begin
            end
         endcase
      end

      last_req_in = last_req_ff;
      if (load_rsp && raise_req) begin
         last_req_in = now_ff;
      end

      // Expired lookup matches drop out during the scan; an update marks its slot live.
      valid_in = valid_ff;
      if (expire) begin
         valid_in[pipe_idx_ff] = 1'b0;
      end
      if (wr_en) begin
         valid_in[scan_res.target] = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_mac_in   = rsp_mac_ff;
      rsp_req_in   = rsp_req_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         if (cmd_ff == act_pkg::CMD_LOOKUP) begin
            rsp_hit_in = scan_res.hit;
            rsp_mac_in = scan_res.hit ? scan_res.mac : '0;
            rsp_req_in = raise_req;
         end else begin
            rsp_hit_in = 1'b0;
            rsp_mac_in = '0;
            rsp_req_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= act_pkg::ST_IDLE;
         cnt_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         timeout_ff   <= act_pkg::TIMEOUT_RESET;
         gap_ff       <= act_pkg::GAP_RESET;
         last_req_ff  <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pipe_vld_ff  <= pipe_vld_in;
         timeout_ff   <= timeout_in;
         gap_ff       <= gap_in;
         last_req_ff  <= last_req_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pipe_idx_ff <= pipe_idx_in;
      cmd_ff      <= cmd_in;
      ip_ff       <= ip_in;
      mac_ff      <= mac_in;
      now_ff      <= now_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_mac_ff  <= rsp_mac_in;
      rsp_req_ff  <= rsp_req_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_mac_out      = rsp_mac_ff;
   assign rsp_send_request = rsp_req_ff;

endmodule

FILE: bench/arp_cache_checker.sv
`timescale 1ns / 100ps

module arp_cache_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [act_pkg::IP_W-1:0]       req_ip_addr,
   input  logic [act_pkg::MAC_W-1:0]      req_mac_in,
   input  logic [act_pkg::TIME_W-1:0]     req_now_ms,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_hit,
   input  logic [act_pkg::MAC_W-1:0]      rsp_mac_out,
   input  logic                           rsp_send_request,
   input  logic                           csr_wr_en,
   input  logic [act_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [act_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             pending_count,
   output int                             fail_count
);
   import act_pkg::*;

   typedef struct packed {
      logic             hit;
      logic [MAC_W-1:0] mac;
      logic             send_request;
   } answer_type;

   answer_type        answer_q[$];
   logic              cache_valid[ENTRIES];
   logic [IP_W-1:0]   cache_ip[ENTRIES];
   logic [MAC_W-1:0]  cache_mac[ENTRIES];
   logic [TIME_W-1:0] cache_stamp[ENTRIES];
   logic [TIME_W-1:0] last_request_ms;
   logic [TIME_W-1:0] timeout_ms;
   logic [TIME_W-1:0] gap_ms;
   int                failures;

   initial failures = 0;
   assign fail_count = failures;

   // Applies one transaction to the shadow table and returns the answer it produces.
   task automatic resolve_address(input logic cmd, input logic [IP_W-1:0] ip,
                                  input logic [MAC_W-1:0] mac, input logic [TIME_W-1:0] now,
                                  output answer_type ans);
      int                target;
      int                victim;
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] since;
      ans = '0;
      if (cmd == CMD_UPDATE) begin
         target = -1;
         victim = 0;
         for (int slot = 0; slot < ENTRIES; slot++) begin
            if (cache_valid[slot] && cache_ip[slot] == ip) begin
               target = slot;
               break;
            end
            if (target < 0 && !cache_valid[slot])
               target = slot;
            if (cache_stamp[slot] < cache_stamp[victim])
               victim = slot;
         end
         if (target < 0)
            target = victim;
         cache_ip[target]    = ip;
         cache_mac[target]   = mac;
         cache_stamp[target] = now;
         cache_valid[target] = 1'b1;
      end else begin
         for (int slot = 0; slot < ENTRIES; slot++) begin
            if (cache_valid[slot] && cache_ip[slot] == ip) begin
               age = now - cache_stamp[slot];
               if (age > timeout_ms) begin
                  cache_valid[slot] = 1'b0;
               end else begin
                  ans.hit = 1'b1;
                  ans.mac = cache_mac[slot];
                  break;
               end
            end
         end
         if (!ans.hit) begin
            since = now - last_request_ms;
            if (since > gap_ms) begin
               ans.send_request = 1'b1;
               last_request_ms  = now;
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      answer_type want;
      answer_type fresh;
      if (reset) begin
         for (int slot = 0; slot < ENTRIES; slot++) begin
            cache_valid[slot] = 1'b0;
            cache_ip[slot]    = '0;
            cache_mac[slot]   = '0;
            cache_stamp[slot] = '0;
         end
         last_request_ms = '0;
         timeout_ms      = TIMEOUT_RESET;
         gap_ms          = GAP_RESET;
         answer_q.delete();
         pending_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ENTRY_TIMEOUT: timeout_ms = csr_wdata;
               CSR_REQUEST_GAP:   gap_ms = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               $error("result transaction with no answer outstanding");
               failures++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, rsp_hit);
                  failures++;
               end
               if (rsp_mac_out !== want.mac) begin
                  $error("mac_out: expected %h, actual %h", want.mac, rsp_mac_out);
                  failures++;
               end
               if (rsp_send_request !== want.send_request) begin
                  $error("send_request: expected %0d, actual %0d",
                         want.send_request, rsp_send_request);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            resolve_address(req_cmd, req_ip_addr, req_mac_in, req_now_ms, fresh);
            answer_q.push_back(fresh);
         end
         pending_count <= answer_q.size();
      end
   end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import act_pkg::*;

   // An index that maps to no register; writes to it must leave the cache untouched.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   // Generous ceiling on the whole run, far above the slowest legal schedule.
   localparam int CYCLE_LIMIT = 600000;
   // Length of the one long receiver hold-off.
   localparam int HOLD_CYCLES = 800;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_cmd;
   logic [IP_W-1:0]       req_ip_addr;
   logic [MAC_W-1:0]      req_mac_in;
   logic [TIME_W-1:0]     req_now_ms;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_hit;
   logic [MAC_W-1:0]      rsp_mac_out;
   logic                  rsp_send_request;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    pending_count;
   int                    fail_count;

   // When calm is set neither side idles; hold_go starts the long receiver hold-off.
   logic                  calm;
   logic                  hold_go;

   // Addresses that the random part draws from, so that updates and lookups meet.
   logic [IP_W-1:0]       ip_pool[96];
   // Running millisecond clock handed to the block with every transaction.
   logic [TIME_W-1:0]     clock_ms;

   arp_cache_table_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_ip_addr      (req_ip_addr),
      .req_mac_in       (req_mac_in),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_mac_out      (rsp_mac_out),
      .rsp_send_request (rsp_send_request),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // The checker sees exactly the pins that the block sees and keeps its own shadow cache.
   arp_cache_checker u_arp_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_ip_addr      (req_ip_addr),
      .req_mac_in       (req_mac_in),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_mac_out      (rsp_mac_out),
      .rsp_send_request (rsp_send_request),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .pending_count    (pending_count),
      .fail_count       (fail_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Watchdog: if the run has not ended by the limit, something hung.
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Result side. The receiver stalls at random, 23 times in a hundred, unless the bench is
   // calm. Once hold_go is seen it refuses results for a long stretch, so the block backs
   // up and has to stall its own input while the sender keeps offering transactions.
   initial begin : receiver
      logic held;
      held      = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 23);
         end
      end
   end

   // Offers one transaction and returns at the edge that accepts it. Random idle cycles
   // go in front of it; valid only drops when an idle cycle is really inserted, so a
   // back-to-back transaction keeps valid high across the edge.
   task automatic send_item(input logic cmd, input logic [IP_W-1:0] ip,
                            input logic [MAC_W-1:0] mac, input logic [TIME_W-1:0] now);
      if (!calm) begin
         while ($urandom_range(99) < 23) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_ip_addr <= ip;
      req_mac_in  <= mac;
      req_now_ms  <= now;
      do @(posedge clock); while (req_stall);
   endtask

   // Drops valid, waits for every outstanding answer and then one full scan more, so
   // that the block is surely idle afterwards.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (ENTRIES + 4) @(posedge clock);
   endtask

   // One random phase. The block is drained, both registers get new values (plus a
   // write to an unused index), and then n_items transactions follow. Most use
   // addresses from the first pool_n pool entries and a clock that creeps forward by
   // up to step_max; a noise share uses a fully random address, and half of the noise
   // also jumps the clock to a random point so that ages wrap.
   task automatic run_phase(input logic [TIME_W-1:0] timeout, input logic [TIME_W-1:0] gap,
                            input int n_items, input int pool_n, input int step_max,
                            input int look_pct, input int noise_pct, input logic quiet,
                            input int hold_at);
      logic              cmd;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
      logic [31:0]       mac_hi;
      logic              noisy;
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ENTRY_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      csr_index <= CSR_REQUEST_GAP;
      csr_wdata <= gap;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      calm      <= quiet;
      @(posedge clock);
      for (int k = 0; k < n_items; k++) begin
         if (k == hold_at)
            hold_go <= 1'b1;
         noisy  = ($urandom_range(99) < noise_pct);
         cmd    = ($urandom_range(99) < look_pct) ? CMD_LOOKUP : CMD_UPDATE;
         ip     = noisy ? $urandom : ip_pool[$urandom_range(pool_n - 1)];
         mac_hi = $urandom;
         mac    = {mac_hi[15:0], $urandom};
         if (noisy && $urandom_range(1) == 1)
            clock_ms = $urandom;
         else
            clock_ms = clock_ms + $urandom_range(step_max);
         send_item(cmd, ip, mac, clock_ms);
      end
   endtask

   initial begin : stimulus
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_UPDATE;
      req_ip_addr = '0;
      req_mac_in  = '0;
      req_now_ms  = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_ENTRY_TIMEOUT;
      csr_wdata   = '0;
      calm        = 1'b0;
      hold_go     = 1'b0;
      clock_ms    = '0;

      // The address extremes sit in the pool so that random traffic reaches them too.
      ip_pool[0] = '0;
      ip_pool[1] = '1;
      for (int p = 2; p < 96; p++)
         ip_pool[p] = $urandom;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run with the register defaults (timeout 30000, gap 200).
      // Lookups on an empty table: the first miss is too close to time zero for a
      // request, the second is just past the gap.
      send_item(CMD_LOOKUP, '0, '0, 32'd0);
      send_item(CMD_LOOKUP, '1, '1, 32'd201);
      // Extreme addresses and stamps; the second entry is stamped at the top of time.
      send_item(CMD_UPDATE, '0, '0, 32'd300);
      send_item(CMD_UPDATE, '1, '1, '1);
      send_item(CMD_LOOKUP, '0, '0, 32'd400);
      // The age of the top-stamped entry wraps around zero and stays small.
      send_item(CMD_LOOKUP, '1, '0, 32'h10);
      // Same address again replaces the entry in place.
      send_item(CMD_UPDATE, '0, 48'h1234_5678_9ABC, 32'd500);
      // An age equal to the timeout is still live; one more millisecond expires it.
      send_item(CMD_LOOKUP, '0, '0, 32'd30500);
      send_item(CMD_LOOKUP, '0, '0, 32'd30501);
      // A miss right after a request stays quiet.
      send_item(CMD_LOOKUP, '0, '0, 32'd30502);
      // Slot zero is now invalid, yet the update must land on the live match behind it.
      send_item(CMD_UPDATE, '1, 48'hA5A5_5A5A_C3C3, 32'd30600);
      send_item(CMD_LOOKUP, '1, '0, 32'd30601);
      // A new address takes the first free slot.
      send_item(CMD_UPDATE, 32'h0A00_0007, 48'h5A5A_A5A5_3C3C, 32'd30700);
      send_item(CMD_LOOKUP, 32'h0A00_0007, '0, 32'd30701);
      // Request gap edges: 201 ms raises, exactly 200 ms does not, 201 ms raises again.
      send_item(CMD_LOOKUP, 32'h0A00_0008, '0, 32'd30702);
      send_item(CMD_LOOKUP, 32'h0A00_0009, '0, 32'd30902);
      send_item(CMD_LOOKUP, 32'h0A00_0009, '0, 32'd30903);
      clock_ms = 32'd31000;

      // Short lifetimes on a small pool: frequent expiry and requests.
      run_phase(32'd1000, 32'd50, 200, 12, 60, 50, 5, 1'b0, -1);
      // Largest register values over a pool larger than the table: mostly updates, so
      // the table fills and the oldest stamp gets replaced; no requests can be raised.
      run_phase('1, '1, 200, 96, 1000, 20, 5, 1'b0, -1);
      // Zero timeout and gap: only same-millisecond lookups hit.
      run_phase('0, '0, 150, 20, 3, 50, 5, 1'b0, -1);
      // Random settings with no idling on either side, and the long receiver hold-off.
      run_phase($urandom_range(5000), $urandom_range(500), 250, 40, 300, 50, 10, 1'b1, 40);
      // Back to the defaults with more noise.
      run_phase(TIMEOUT_RESET, GAP_RESET, 250, 70, 500, 45, 15, 1'b0, -1);

      wait_idle();
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: arp_cache_table_top.f
design/act_pkg.sv
design/act_ram.sv
design/act_scan_unit.sv
design/arp_cache_table_top.sv
bench/arp_cache_checker.sv
bench/tb_top.sv
